[rtl/servo_damper_move_supervisor_defines.svh]
// Assertion macros for the damper servo move supervisor checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SERVO_DAMPER_MOVE_SUPERVISOR_DEFINES_SVH
`define SERVO_DAMPER_MOVE_SUPERVISOR_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define SDMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SDMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sdms_pkg.sv]
// Types and constants shared by the damper servo move supervisor.
// No dependencies.
package sdms_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TIMER_CFG_W = 16;
  localparam int PADDR_W = 5;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] NEUTRAL_RESET = 7'd50;
  localparam logic signed [20:0] ROUND_HALF = 21'sd50;

  // floor(a / 100) == (a * RECIP_MUL) >> RECIP_SHIFT for a below 2^19
  localparam logic [19:0] RECIP_MUL = 20'd671089;
  localparam int RECIP_SHIFT = 26;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_MODE   = 2'd2,
    CMD_PARK   = 2'd3
  } cmd_t;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_CLOSED = 2'd2;
  localparam logic [1:0] MODE_OPEN   = 2'd3;

  typedef enum logic [2:0] {
    REG_STALL_THRESHOLD  = 3'd0,
    REG_STALL_CONFIRM_MS = 3'd1,
    REG_SETTLE_MS        = 3'd2,
    REG_CLOSED_PULSE_US  = 3'd3,
    REG_OPEN_PULSE_US    = 3'd4,
    REG_NEUTRAL_PERCENT  = 3'd5,
    REG_STALLED_CODE     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  target_percent;
    logic [1:0]  mode_code;
    logic [11:0] current_sample;
  } item_t;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic        servo_enable;
    logic [6:0]  target_pos;
    logic [6:0]  actual_pos;
    logic        stall_flag;
    logic [7:0]  reported_mode;
  } result_t;

  typedef struct packed {
    logic [11:0] stall_threshold;
    logic [15:0] stall_confirm_ms;
    logic [15:0] settle_ms;
    logic [11:0] closed_pulse_us;
    logic [11:0] open_pulse_us;
    logic [6:0]  neutral_percent;
    logic [7:0]  stalled_code;
  } cfg_t;

  // Supervisor state as it stands after one item.
  typedef struct packed {
    logic       powered;
    logic [6:0] target;
    logic [6:0] actual;
    logic       stalled;
    logic [1:0] mode;
  } snap_t;

  function automatic logic [6:0] clamp_pct(input logic [7:0] p);
    clamp_pct = (p > {1'b0, PCT_MAX}) ? PCT_MAX : p[6:0];
  endfunction

endpackage

[rtl/servo_damper_move_supervisor.sv]
// Top level of the damper servo move supervisor: register file, state, result pipeline.
// Depends on sdms_pkg, sdms_ctrl and sdms_pulse_pipe.
//
// Use: the item channel (item_valid, item_stall, item) carries one command or
// millisecond tick per transfer; the result channel (result_valid,
// result_stall, result) returns exactly one result per item, in order,
// holding pulse width, power enable, target, actual, stall flag and mode.
// A transfer completes at a rising edge with valid high and stall low.
// A result becomes valid when it reaches the result register.
// Throughput: one item per cycle while item_stall is low; the supervisor
// state updates in the transfer cycle and the pulse interpolation runs
// through three registered stages (product, reciprocal multiply for the
// divide by 100, result). When the receiver stalls, the pipeline holds up
// to three results and then raises item_stall; no result is dropped or
// repeated.
// Reset (rst, synchronous) empties the pipeline, loads the register
// defaults and parks the state at 50 percent, unpowered, in auto mode.
// Configuration uses an APB-style port, one 32-bit register per word;
// write it only while no item is in flight.
module servo_damper_move_supervisor import sdms_pkg::*; #(
  parameter int TIMER_BITS  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  snap_t    snap_next;
  logic     take_ok, accept, cfg_write;
  reg_idx_t reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

  // Register file: write on the access phase, reset to the documented defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_threshold  <= 12'd2048;
      cfg.stall_confirm_ms <= 16'd100;
      cfg.settle_ms        <= 16'd2000;
      cfg.closed_pulse_us  <= 12'd1000;
      cfg.open_pulse_us    <= 12'd2000;
      cfg.neutral_percent  <= NEUTRAL_RESET;
      cfg.stalled_code     <= 8'd255;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_STALL_THRESHOLD:  cfg.stall_threshold  <= pwdata[11:0];
        REG_STALL_CONFIRM_MS: cfg.stall_confirm_ms <= pwdata[15:0];
        REG_SETTLE_MS:        cfg.settle_ms        <= pwdata[15:0];
        REG_CLOSED_PULSE_US:  cfg.closed_pulse_us  <= pwdata[11:0];
        REG_OPEN_PULSE_US:    cfg.open_pulse_us    <= pwdata[11:0];
        REG_NEUTRAL_PERCENT:  cfg.neutral_percent  <= pwdata[6:0];
        REG_STALLED_CODE:     cfg.stalled_code     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back; unused addresses return zero.
  always_comb begin
    unique case (reg_idx)
      REG_STALL_THRESHOLD:  prdata = {20'd0, cfg.stall_threshold};
      REG_STALL_CONFIRM_MS: prdata = {16'd0, cfg.stall_confirm_ms};
      REG_SETTLE_MS:        prdata = {16'd0, cfg.settle_ms};
      REG_CLOSED_PULSE_US:  prdata = {20'd0, cfg.closed_pulse_us};
      REG_OPEN_PULSE_US:    prdata = {20'd0, cfg.open_pulse_us};
      REG_NEUTRAL_PERCENT:  prdata = {25'd0, cfg.neutral_percent};
      REG_STALLED_CODE:     prdata = {24'd0, cfg.stalled_code};
      default:              prdata = 32'd0;
    endcase
  end

  // Hold the input only when every pipeline stage is full and blocked.
  assign item_stall = !take_ok;
  assign accept     = item_valid && take_ok;

  sdms_ctrl #(
    .TIMER_BITS  (TIMER_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .snap_next (snap_next)
  );

  sdms_pulse_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .snap         (snap_next),
    .cfg          (cfg),
    .take_ok      (take_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[rtl/sdms_ctrl.sv]
// Move supervisor state: target, actual, mode, power, stall and the two timers.
// Depends on sdms_pkg.
module sdms_ctrl import sdms_pkg::*; #(
  parameter int TIMER_BITS  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  input  cfg_t  cfg,
  output snap_t snap_next
);

  localparam int CMP_W = (TIMER_BITS > TIMER_CFG_W) ? TIMER_BITS : TIMER_CFG_W;
  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [6:0] target, target_next;
  logic [6:0] actual, actual_next;
  logic [1:0] mode, mode_next;
  logic       powered, powered_next;
  logic       stalled, stalled_next;
  logic [TIMER_BITS-1:0] settle_elapsed, settle_elapsed_next;
  logic       overload_running, overload_running_next;
  logic [TIMER_BITS-1:0] overload_elapsed, overload_elapsed_next;

  logic [TIMER_BITS-1:0] settle_adv, overload_adv;
  logic [6:0] neutral, tp_clamped, move_tgt;
  logic       over, settle_done, overload_hit, move_go, cut;

  assign neutral    = clamp_pct({1'b0, cfg.neutral_percent});
  assign tp_clamped = clamp_pct(item.target_percent);
  assign over = item.current_sample[SW-1:0] >= cfg.stall_threshold[SW-1:0];

  // Saturating advance of both timers.
  assign settle_adv = (settle_elapsed == '1) ? settle_elapsed
                                             : settle_elapsed + TIMER_BITS'(1);
  assign overload_adv = (overload_elapsed == '1) ? overload_elapsed
                                                 : overload_elapsed + TIMER_BITS'(1);
  assign settle_done  = CMP_W'(settle_adv) >= CMP_W'(cfg.settle_ms);
  assign overload_hit = CMP_W'(overload_adv) >= CMP_W'(cfg.stall_confirm_ms);

  always_comb begin
    target_next           = target;
    actual_next           = actual;
    mode_next             = mode;
    powered_next          = powered;
    stalled_next          = stalled;
    settle_elapsed_next   = settle_elapsed;
    overload_running_next = overload_running;
    overload_elapsed_next = overload_elapsed;
    move_go  = 1'b0;
    move_tgt = target;
    cut      = 1'b0;

    unique case (cmd_t'(item.cmd))
      CMD_TICK: begin
        if (powered) begin
          settle_elapsed_next = settle_adv;
          if (over) begin
            if (!overload_running) begin
              overload_running_next = 1'b1;
              overload_elapsed_next = '0;
            end else if (overload_hit) begin
              stalled_next = 1'b1;
              cut          = 1'b1;
            end else begin
              overload_elapsed_next = overload_adv;
            end
          end else begin
            overload_running_next = 1'b0;
            overload_elapsed_next = '0;
          end
          // a stall ends the tick before the settle check
          if (!(over && overload_running && overload_hit) && settle_done) begin
            actual_next = target;
            cut         = 1'b1;
          end
        end
      end
      CMD_TARGET: begin
        if (!(tp_clamped == target && !powered)) begin
          move_go  = 1'b1;
          move_tgt = tp_clamped;
        end
      end
      CMD_MODE: begin
        mode_next = item.mode_code;
        if (item.mode_code == MODE_CLOSED) begin
          if (!(target == 7'd0 && !powered)) begin
            move_go  = 1'b1;
            move_tgt = 7'd0;
          end
        end else if (item.mode_code == MODE_OPEN) begin
          if (!(target == PCT_MAX && !powered)) begin
            move_go  = 1'b1;
            move_tgt = PCT_MAX;
          end
        end
      end
      CMD_PARK: begin
        if (!(!powered && target == neutral && actual == neutral)) begin
          move_go  = 1'b1;
          move_tgt = neutral;
        end
      end
      default: begin
      end
    endcase

    if (cut) begin
      powered_next          = 1'b0;
      settle_elapsed_next   = '0;
      overload_running_next = 1'b0;
      overload_elapsed_next = '0;
    end
    if (move_go) begin
      target_next           = move_tgt;
      stalled_next          = 1'b0;
      powered_next          = 1'b1;
      settle_elapsed_next   = '0;
      overload_running_next = 1'b0;
      overload_elapsed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target           <= NEUTRAL_RESET;
      actual           <= NEUTRAL_RESET;
      mode             <= MODE_AUTO;
      powered          <= 1'b0;
      stalled          <= 1'b0;
      settle_elapsed   <= '0;
      overload_running <= 1'b0;
      overload_elapsed <= '0;
    end else if (accept) begin
      target           <= target_next;
      actual           <= actual_next;
      mode             <= mode_next;
      powered          <= powered_next;
      stalled          <= stalled_next;
      settle_elapsed   <= settle_elapsed_next;
      overload_running <= overload_running_next;
      overload_elapsed <= overload_elapsed_next;
    end
  end

  assign snap_next = '{powered: powered_next, target: target_next, actual: actual_next,
                       stalled: stalled_next, mode: mode_next};

endmodule

[rtl/sdms_pulse_pipe.sv]
// Three-stage result pipeline: interpolation product, divide by 100, result register.
// Depends on sdms_pkg.
module sdms_pulse_pipe import sdms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  snap_t   snap,
  input  cfg_t    cfg,
  output logic    take_ok,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  snap_t s1_snap, s2_snap;
  logic signed [20:0] s1_prod;
  logic        s2_neg;
  logic [11:0] s2_q;

  logic signed [20:0] d_x, t_x, prod_c, abs_c;
  logic [38:0] recip_c;
  logic [12:0] sum_c;

  // A stage moves on when it is empty or its successor moves on.
  assign adv3    = !v3 || !result_stall;
  assign adv2    = !v2 || adv3;
  assign adv1    = !v1 || adv2;
  assign take_ok = adv1;

  assign d_x    = 21'(signed'({1'b0, cfg.open_pulse_us})) -
                  21'(signed'({1'b0, cfg.closed_pulse_us}));
  assign t_x    = signed'({14'd0, snap.target});
  assign prod_c = d_x * t_x + ROUND_HALF;

  assign abs_c   = s1_prod[20] ? -s1_prod : s1_prod;
  assign recip_c = abs_c[18:0] * RECIP_MUL;

  assign sum_c = s2_neg ? ({1'b0, cfg.closed_pulse_us} - {1'b0, s2_q})
                        : ({1'b0, cfg.closed_pulse_us} + {1'b0, s2_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= load;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_snap <= snap;
      s1_prod <= prod_c;
    end
    if (adv2) begin
      s2_snap <= s1_snap;
      s2_neg  <= s1_prod[20];
      s2_q    <= recip_c[RECIP_SHIFT+11:RECIP_SHIFT];
    end
    if (adv3) begin
      result.pulse_us      <= s2_snap.powered ? sum_c[11:0] : 12'd0;
      result.servo_enable  <= s2_snap.powered;
      result.target_pos    <= s2_snap.target;
      result.actual_pos    <= s2_snap.actual;
      result.stall_flag    <= s2_snap.stalled;
      result.reported_mode <= s2_snap.stalled ? cfg.stalled_code : {6'd0, s2_snap.mode};
    end
  end

  assign result_valid = v3;

endmodule

[rtl/sdms_checker.sv]
// Port-level checker for the damper servo move supervisor, bound to the top level.
// Depends on sdms_pkg and servo_damper_move_supervisor_defines.svh.
`include "servo_damper_move_supervisor_defines.svh"

module sdms_checker import sdms_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input item_t              item,
  input logic               result_valid,
  input logic               result_stall,
  input result_t            result,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  `SDMS_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `SDMS_ASSERT(a_stall_unpowered, result_valid && result.stall_flag |-> !result.servo_enable && result.pulse_us == 12'd0, "stall flag with power on")
  `SDMS_ASSERT(a_backpressure, item_stall |-> result_valid && result_stall, "input held without output backpressure")
  `SDMS_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

endmodule

bind servo_damper_move_supervisor sdms_checker u_checker (.*);
